[src/kmc_pkg.sv]
// Shared types and constants of the 2-D k-means clustering block.
package kmc_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int FIELD_W  = 16;
    localparam int LABEL_W  = 4;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OP_LOAD_POINT    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_CENTROID = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RUN           = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ    = 2'd3;

    localparam logic REC_CENTROID = 1'b0;
    localparam logic REC_LABEL    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ASSIGN,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_DECIDE,
        ST_EMIT_CEN,
        ST_EMIT_LBL
    } kmc_state_t;

    typedef struct packed {
        logic clear;
        logic div_start;
        logic div_step;
        logic commit;
    } kmc_ctrl_t;

endpackage

[src/kmeans_2d_clustering.sv]
// Top level of the 2-D Lloyd k-means clustering block.
//
// Input channel (valid/ready): each beat carries an opcode, a slot index and a
// Q8.8 coordinate pair. Load beats write a point or an initial centroid and
// are taken one per cycle while the block is idle. A run beat starts
// clustering; ready stays low until the last result beat has been loaded into
// the output register.
// A run makes up to iteration_limit passes (one when the limit is zero). One pass
// clears the sums and streams the points through a row of MAX_CENTROIDS cells
// (one per cluster), then divides all cluster sums in parallel bit by bit, then
// decides whether to go on. The bit-serial mean and the cell row latency set the
// pass length.
// Output channel (valid/ready): k centroid beats then n label beats, one per
// cycle when the receiver is ready; last marks the final beat. A stalled
// receiver holds the output register and the sequencer waits.
// Configuration writes are registered and must happen while idle.
// Reset returns the registers to their defaults and empties both channels;
// stores keep no valid bits and must be loaded before a run.
module kmeans_2d_clustering
    import kmc_pkg::*;
#(
    parameter int MAX_POINTS    = 48,
    parameter int MAX_CENTROIDS = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic signed [FIELD_W-1:0] coord_x,
    input  logic signed [FIELD_W-1:0] coord_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 record_kind,
    output logic [INDEX_W-1:0]   record_index,
    output logic signed [FIELD_W-1:0] out_x,
    output logic signed [FIELD_W-1:0] out_y,
    output logic [LABEL_W-1:0]   out_label,
    output logic                 converged,
    output logic                 last
);

    localparam int CW  = COORD_WIDTH;
    localparam int MP  = MAX_POINTS;
    localparam int MC  = MAX_CENTROIDS;
    localparam int AW  = $clog2(MP);
    localparam int NW  = $clog2(MP + 1);
    localparam int KW  = $clog2(MC + 1);
    localparam int LW  = (MC > 1) ? $clog2(MC) : 1;
    localparam int SW  = CW + NW;
    localparam int STW = $clog2(SW + 1);
    localparam int EW  = (NW > KW) ? NW : KW;
    localparam int DSW = (2 * CW + 1 > 64) ? 64 : 2 * CW + 1;

    // configuration registers
    logic [5:0]       point_count_reg;
    logic [4:0]       centroid_count_reg;
    logic [7:0]       iteration_limit_reg;
    logic [CFG_W-1:0] threshold_sq_reg;

    kmc_state_t state_reg, state_next;
    kmc_ctrl_t  ctrl;

    logic [NW-1:0]  n_reg;
    logic [KW-1:0]  k_reg;
    logic [7:0]     lim_reg;
    logic [7:0]     pass_reg;
    logic [NW-1:0]  issue_cnt_reg;
    logic [NW-1:0]  exit_cnt_reg;
    logic [STW-1:0] step_cnt_reg;
    logic [EW-1:0]  eidx_reg, eidx_next;
    logic           converged_reg;

    logic            rd_valid_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic [2*CW-1:0] rd_data_reg;
    logic [2*CW-1:0] pmem [MP];
    logic [LW-1:0]   lmem [MP];
    logic [LW-1:0]   lbl_rd_reg;

    logic                 out_valid_reg;
    logic                 kind_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic [FIELD_W-1:0]   x_reg;
    logic [FIELD_W-1:0]   y_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic                 conv_reg;
    logic                 last_reg;

    logic accept;
    logic load_point;
    logic load_centroid;
    logic start_run;
    logic issue;
    logic exit_beat;
    logic last_exit;
    logic all_settled;
    logic emit_ld;
    logic [NW-1:0] n_next;
    logic [KW-1:0] k_next;

    logic signed [CW-1:0] in_cx;
    logic signed [CW-1:0] in_cy;

    // cell row wiring, position 0 is the row input
    logic                 ch_valid [MC+1];
    logic signed [CW-1:0] ch_x     [MC+1];
    logic signed [CW-1:0] ch_y     [MC+1];
    logic [AW-1:0]        ch_idx   [MC+1];
    logic                 ch_have  [MC+1];
    logic [DSW-1:0]       ch_dist  [MC+1];
    logic [LW-1:0]        ch_label [MC+1];
    logic [MC-1:0]        active;
    logic [MC-1:0]        moved;
    logic signed [CW-1:0] cen_x [MC];
    logic signed [CW-1:0] cen_y [MC];

    assign accept        = in_valid && in_ready;
    assign load_point    = accept && (opcode == OP_LOAD_POINT) && (32'(entry_index) < MP);
    assign load_centroid = accept && (opcode == OP_LOAD_CENTROID);
    assign start_run     = accept && (opcode == OP_RUN);

    // input coordinates use their low CW bits, zero-extended when CW is wider
    assign in_cx = CW'($unsigned(coord_x));
    assign in_cy = CW'($unsigned(coord_y));

    // clamp counts at the start of a run
    assign n_next = (point_count_reg == '0) ? NW'(1) :
                    (32'(point_count_reg) > MP) ? NW'(MP) : NW'(point_count_reg);
    assign k_next = (centroid_count_reg == '0) ? KW'(1) :
                    (32'(centroid_count_reg) > MC) ? KW'(MC) : KW'(centroid_count_reg);

    assign issue       = (state_reg == ST_ASSIGN) && (issue_cnt_reg < n_reg);
    assign exit_beat   = ch_valid[MC];
    assign last_exit   = exit_beat && (exit_cnt_reg == n_reg - NW'(1));
    assign all_settled = ~|moved;
    assign emit_ld     = ((state_reg == ST_EMIT_CEN) || (state_reg == ST_EMIT_LBL)) &&
                         (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_ASSIGN;
            end
            ST_ASSIGN:
            begin
                if (last_exit)
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (step_cnt_reg == STW'(SW - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (all_settled || (pass_reg >= lim_reg))
                begin
                    state_next = ST_EMIT_CEN;
                end
                else
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_EMIT_CEN:
            begin
                if (emit_ld && (eidx_reg == EW'(k_reg - KW'(1))))
                begin
                    state_next = ST_EMIT_LBL;
                end
            end
            ST_EMIT_LBL:
            begin
                if (emit_ld && (eidx_reg == EW'(n_reg - NW'(1))))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CLEAR:
            begin
                ctrl.clear = 1'b1;
            end
            ST_DIV_LOAD:
            begin
                ctrl.div_start = 1'b1;
            end
            ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
            end
            ST_DECIDE:
            begin
                ctrl.commit = !(all_settled || (pass_reg >= lim_reg));
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // emission index; its next value drives the label read address, so the read label matches the current index
    always_comb
    begin
        eidx_next = eidx_reg;
        if (state_reg == ST_DECIDE)
        begin
            eidx_next = '0;
        end
        else if (emit_ld)
        begin
            if ((state_reg == ST_EMIT_CEN) && (eidx_reg == EW'(k_reg - KW'(1))))
            begin
                eidx_next = '0;
            end
            else
            begin
                eidx_next = eidx_reg + EW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            point_count_reg     <= 6'd48;
            centroid_count_reg  <= 5'd16;
            iteration_limit_reg <= 8'd100;
            threshold_sq_reg    <= '0;
            n_reg               <= '0;
            k_reg               <= '0;
            lim_reg             <= '0;
            pass_reg            <= '0;
            issue_cnt_reg       <= '0;
            exit_cnt_reg        <= '0;
            step_cnt_reg        <= '0;
            eidx_reg            <= '0;
            converged_reg       <= 1'b0;
            rd_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eidx_reg     <= eidx_next;
            rd_valid_reg <= issue;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_POINT_COUNT:     point_count_reg     <= cfg_wr_data[5:0];
                    REG_CENTROID_COUNT:  centroid_count_reg  <= cfg_wr_data[4:0];
                    REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_wr_data[7:0];
                    REG_THRESHOLD_SQ:    threshold_sq_reg    <= cfg_wr_data;
                    default:             threshold_sq_reg    <= threshold_sq_reg;
                endcase
            end

            if (start_run)
            begin
                n_reg    <= n_next;
                k_reg    <= k_next;
                lim_reg  <= (iteration_limit_reg == '0) ? 8'd1 : iteration_limit_reg;
                pass_reg <= '0;
            end

            if (state_reg == ST_CLEAR)
            begin
                pass_reg      <= pass_reg + 8'd1;
                issue_cnt_reg <= '0;
                exit_cnt_reg  <= '0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + NW'(1);
                end
                if (exit_beat)
                begin
                    exit_cnt_reg <= exit_cnt_reg + NW'(1);
                end
            end

            if (state_reg == ST_DIVIDE)
            begin
                step_cnt_reg <= step_cnt_reg + STW'(1);
            end
            else
            begin
                step_cnt_reg <= '0;
            end

            if (state_reg == ST_DECIDE)
            begin
                converged_reg <= all_settled;
            end

            // hold the output beat until taken, then drop or refill
            if (emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // point store: loads write, the assignment pass reads one point a cycle
    always_ff @(posedge clk)
    begin
        if (load_point)
        begin
            pmem[AW'(entry_index)] <= {in_cy, in_cx};
        end
        if (issue)
        begin
            rd_data_reg <= pmem[issue_cnt_reg[AW-1:0]];
            rd_idx_reg  <= issue_cnt_reg[AW-1:0];
        end
    end

    // label store: written as points leave the row, read during emission
    always_ff @(posedge clk)
    begin
        if (exit_beat)
        begin
            lmem[ch_idx[MC]] <= ch_label[MC];
        end
        lbl_rd_reg <= lmem[eidx_next[AW-1:0]];
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit_ld)
        begin
            conv_reg  <= converged_reg;
            index_reg <= INDEX_W'(eidx_reg);
            if (state_reg == ST_EMIT_CEN)
            begin
                kind_reg  <= REC_CENTROID;
                x_reg     <= FIELD_W'($unsigned(cen_x[eidx_reg[LW-1:0]]));
                y_reg     <= FIELD_W'($unsigned(cen_y[eidx_reg[LW-1:0]]));
                label_reg <= '0;
                last_reg  <= 1'b0;
            end
            else
            begin
                kind_reg  <= REC_LABEL;
                x_reg     <= '0;
                y_reg     <= '0;
                label_reg <= LABEL_W'(lbl_rd_reg);
                last_reg  <= (eidx_reg == EW'(n_reg - NW'(1)));
            end
        end
    end

    // row input: a fresh point with no candidate yet
    assign ch_valid[0] = rd_valid_reg;
    assign ch_x[0]     = rd_data_reg[CW-1:0];
    assign ch_y[0]     = rd_data_reg[2*CW-1:CW];
    assign ch_idx[0]   = rd_idx_reg;
    assign ch_have[0]  = 1'b0;
    assign ch_dist[0]  = '0;
    assign ch_label[0] = '0;

    genvar j;
    generate
        for (j = 0; j < MC; j++) begin : g_cell
            assign active[j] = (KW'(j) < k_reg);

            kmc_cell #(
                .IDX(j),
                .CW (CW),
                .MP (MP),
                .MC (MC)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[j]),
                .ctrl     (ctrl),
                .load_en  (load_centroid),
                .load_idx (entry_index),
                .load_x   (in_cx),
                .load_y   (in_cy),
                .in_valid (ch_valid[j]),
                .in_x     (ch_x[j]),
                .in_y     (ch_y[j]),
                .in_idx   (ch_idx[j]),
                .in_have  (ch_have[j]),
                .in_dist  (ch_dist[j]),
                .in_label (ch_label[j]),
                .fwd_valid(ch_valid[j+1]),
                .fwd_x    (ch_x[j+1]),
                .fwd_y    (ch_y[j+1]),
                .fwd_idx  (ch_idx[j+1]),
                .fwd_have (ch_have[j+1]),
                .fwd_dist (ch_dist[j+1]),
                .fwd_label(ch_label[j+1]),
                .acc_valid(exit_beat),
                .acc_label(ch_label[MC]),
                .acc_x    (ch_x[MC]),
                .acc_y    (ch_y[MC]),
                .thr      (threshold_sq_reg),
                .moved    (moved[j]),
                .cen_x    (cen_x[j]),
                .cen_y    (cen_y[j])
            );
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign record_kind  = kind_reg;
    assign record_index = index_reg;
    assign out_x        = x_reg;
    assign out_y        = y_reg;
    assign out_label    = label_reg;
    assign converged    = conv_reg;
    assign last         = last_reg;

endmodule

[src/kmc_dist.sv]
// Squared Euclidean distance between two points, saturated to 64 bits.
module kmc_dist #(
    parameter int CW = 16,
    localparam int FULL_W = 2 * CW + 1,
    localparam int DSW = (FULL_W > 64) ? 64 : FULL_W
) (
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    output logic [DSW-1:0]       dist_sq
);

    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW-1:0]      mx;
    logic [CW-1:0]      my;
    logic [2*CW-1:0]    sqx;
    logic [2*CW-1:0]    sqy;
    logic [FULL_W-1:0]  sum;

    assign dx  = (CW+1)'(ax) - (CW+1)'(bx);
    assign dy  = (CW+1)'(ay) - (CW+1)'(by);
    // magnitude of a difference never exceeds 2^CW-1
    assign mx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    assign my  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    assign sqx = mx * mx;
    assign sqy = my * my;
    assign sum = FULL_W'(sqx) + FULL_W'(sqy);

    generate
        if (FULL_W > 64) begin : g_sat
            assign dist_sq = (|sum[FULL_W-1:DSW]) ? '1 : sum[DSW-1:0];
        end else begin : g_nosat
            assign dist_sq = sum;
        end
    endgenerate

endmodule

[src/kmc_cell.sv]
// One cluster cell: holds a centroid, labels passing points, accumulates and divides.
module kmc_cell
    import kmc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 16,
    parameter int MP  = 48,
    parameter int MC  = 16,
    localparam int AW  = $clog2(MP),
    localparam int NW  = $clog2(MP + 1),
    localparam int LW  = (MC > 1) ? $clog2(MC) : 1,
    localparam int SW  = CW + NW,
    localparam int DSW = (2 * CW + 1 > 64) ? 64 : 2 * CW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 active,
    input  kmc_ctrl_t            ctrl,
    input  logic                 load_en,
    input  logic [INDEX_W-1:0]   load_idx,
    input  logic signed [CW-1:0] load_x,
    input  logic signed [CW-1:0] load_y,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic [AW-1:0]        in_idx,
    input  logic                 in_have,
    input  logic [DSW-1:0]       in_dist,
    input  logic [LW-1:0]        in_label,
    output logic                 fwd_valid,
    output logic signed [CW-1:0] fwd_x,
    output logic signed [CW-1:0] fwd_y,
    output logic [AW-1:0]        fwd_idx,
    output logic                 fwd_have,
    output logic [DSW-1:0]       fwd_dist,
    output logic [LW-1:0]        fwd_label,
    input  logic                 acc_valid,
    input  logic [LW-1:0]        acc_label,
    input  logic signed [CW-1:0] acc_x,
    input  logic signed [CW-1:0] acc_y,
    input  logic [CFG_W-1:0]     thr,
    output logic                 moved,
    output logic signed [CW-1:0] cen_x,
    output logic signed [CW-1:0] cen_y
);

    localparam int CMPW = (DSW > CFG_W) ? DSW : CFG_W;

    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic                 valid_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic [AW-1:0]        idx_reg;
    logic                 have_reg;
    logic [DSW-1:0]       dist_reg;
    logic [LW-1:0]        label_reg;
    logic signed [SW-1:0] sumx_reg;
    logic signed [SW-1:0] sumy_reg;
    logic [NW-1:0]        cnt_reg;
    logic [SW-1:0]        dvdx_reg;
    logic [SW-1:0]        dvdy_reg;
    logic [NW-1:0]        remx_reg;
    logic [NW-1:0]        remy_reg;
    logic                 negx_reg;
    logic                 negy_reg;

    logic [DSW-1:0]       d;
    logic                 take;
    logic [SW-1:0]        magx;
    logic [SW-1:0]        magy;
    logic [NW:0]          remtx;
    logic [NW:0]          remty;
    logic                 gex;
    logic                 gey;
    logic signed [CW-1:0] newx;
    logic signed [CW-1:0] newy;
    logic [DSW-1:0]       move_d;

    kmc_dist #(.CW(CW)) u_assign_dist (
        .ax(in_x), .ay(in_y), .bx(cx_reg), .by(cy_reg), .dist_sq(d)
    );

    assign take = active && (!in_have || (d < in_dist));

    assign magx  = sumx_reg[SW-1] ? SW'(-sumx_reg) : SW'(sumx_reg);
    assign magy  = sumy_reg[SW-1] ? SW'(-sumy_reg) : SW'(sumy_reg);
    assign remtx = {remx_reg, dvdx_reg[SW-1]};
    assign remty = {remy_reg, dvdy_reg[SW-1]};
    assign gex   = remtx >= {1'b0, cnt_reg};
    assign gey   = remty >= {1'b0, cnt_reg};

    // empty cluster keeps its centroid
    assign newx = (cnt_reg == '0) ? cx_reg : (negx_reg ? CW'(-dvdx_reg) : CW'(dvdx_reg));
    assign newy = (cnt_reg == '0) ? cy_reg : (negy_reg ? CW'(-dvdy_reg) : CW'(dvdy_reg));

    kmc_dist #(.CW(CW)) u_move_dist (
        .ax(newx), .ay(newy), .bx(cx_reg), .by(cy_reg), .dist_sq(move_d)
    );

    assign moved = active && (CMPW'(move_d) > CMPW'(thr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= in_x;
        y_reg     <= in_y;
        idx_reg   <= in_idx;
        have_reg  <= in_have | active;
        dist_reg  <= take ? d : in_dist;
        label_reg <= take ? LW'(IDX) : in_label;

        if (load_en && (load_idx == INDEX_W'(IDX)))
        begin
            cx_reg <= load_x;
            cy_reg <= load_y;
        end
        else if (ctrl.commit && active)
        begin
            cx_reg <= newx;
            cy_reg <= newy;
        end

        if (ctrl.clear)
        begin
            sumx_reg <= '0;
            sumy_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (acc_valid && (acc_label == LW'(IDX)))
        begin
            sumx_reg <= sumx_reg + SW'(acc_x);
            sumy_reg <= sumy_reg + SW'(acc_y);
            cnt_reg  <= cnt_reg + NW'(1);
        end

        if (ctrl.div_start)
        begin
            // round half away from zero: add half the count to the magnitude
            dvdx_reg <= magx + SW'(cnt_reg >> 1);
            dvdy_reg <= magy + SW'(cnt_reg >> 1);
            remx_reg <= '0;
            remy_reg <= '0;
            negx_reg <= sumx_reg[SW-1];
            negy_reg <= sumy_reg[SW-1];
        end
        else if (ctrl.div_step)
        begin
            remx_reg <= gex ? NW'(remtx - {1'b0, cnt_reg}) : remtx[NW-1:0];
            remy_reg <= gey ? NW'(remty - {1'b0, cnt_reg}) : remty[NW-1:0];
            dvdx_reg <= {dvdx_reg[SW-2:0], gex};
            dvdy_reg <= {dvdy_reg[SW-2:0], gey};
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_x     = x_reg;
    assign fwd_y     = y_reg;
    assign fwd_idx   = idx_reg;
    assign fwd_have  = have_reg;
    assign fwd_dist  = dist_reg;
    assign fwd_label = label_reg;
    assign cen_x     = cx_reg;
    assign cen_y     = cy_reg;

endmodule
